@@ hw/rtl/lobm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	// fixed widths of the result fields
	localparam int REF_OUT_W   = 12;
	localparam int PRICE_OUT_W = 10;
	localparam int AMT_W       = 32;
	localparam int OUTCOME_W   = 3;

	// status outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OC_RESTED      = 3'd0,
		OC_FILLED      = 3'd1,
		OC_ID_RANGE    = 3'd2,
		OC_DUPLICATE   = 3'd3,
		OC_POOL_FULL   = 3'd4,
		OC_CANCELLED   = 3'd5,
		OC_NOT_FOUND   = 3'd6,
		OC_PRICE_RANGE = 3'd7
	} outcome_t;

	// input operation codes
	typedef enum logic {
		OP_NEW    = 1'b0,
		OP_CANCEL = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIR,
		ST_CREC,
		ST_CLVL,
		ST_ALLOC,
		ST_SCAN,
		ST_CHK,
		ST_MATCH,
		ST_FIN,
		ST_APPEND,
		ST_STAT
	} st_t;

endpackage

@@ hw/rtl/lobm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_in_if / lobm_out_if
// Valid/ready channels for order items and for fill and status items.
// ----------------------------------------------------------------------------
interface lobm_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] order_ref;
	logic        is_sell;
	logic [31:0] limit_price;
	logic [31:0] amount;

	modport source (output valid, op, order_ref, is_sell, limit_price, amount, input ready);
	modport sink   (input valid, op, order_ref, is_sell, limit_price, amount, output ready);
endinterface

interface lobm_out_if
	import lobm_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic                   is_status;
	logic [REF_OUT_W-1:0]   buyer_ref;
	logic [REF_OUT_W-1:0]   seller_ref;
	logic [PRICE_OUT_W-1:0] trade_price;
	logic [AMT_W-1:0]       trade_amount;
	logic [OUTCOME_W-1:0]   outcome;
	logic                   last;

	modport source (output valid, is_status, buyer_ref, seller_ref, trade_price, trade_amount,
		outcome, last, input ready);
	modport sink   (input valid, is_status, buyer_ref, seller_ref, trade_price, trade_amount,
		outcome, last, output ready);
endinterface

@@ hw/rtl/limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book: id directory, slot records and per-price
// level queues in synchronous RAMs, driven by one read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass initializes the directory,
// level and free-list RAMs; no order is taken meanwhile. An id out of range
// goes straight to the status result; any other item first reads the
// directory. A new order then takes a free slot, scans for the best opposite
// price level, trades against the head of that level until it is filled or
// no level crosses its limit, and rests any remainder at the tail of its own
// level. The scan starts from a tracked bound on the best bid and best ask,
// so it only walks levels that emptied since the last search, one level RAM
// read each. Every result waits in one output register, and the sequencer
// stalls only while that register is full and not taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int ORDER_IDS   = 4096,
	parameter int ORDER_SLOTS = 64,
	parameter int PRICE_TICKS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	lobm_in_if.sink    orders,
	lobm_out_if.source results
);

	localparam int IDW   = $clog2(ORDER_IDS);
	localparam int SW    = $clog2(ORDER_SLOTS);
	localparam int PW    = SW + 1;
	localparam int PRW   = $clog2(PRICE_TICKS);
	localparam int CLR_N = (ORDER_IDS > PRICE_TICKS) ? ORDER_IDS : PRICE_TICKS;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [PW-1:0] NO_SLOT = {PW{1'b1}};

	// memories
	logic [PW-1:0]    dir_mem   [ORDER_IDS];
	logic [IDW-1:0]   ref_mem   [ORDER_SLOTS];
	logic [PRW-1:0]   prc_mem   [ORDER_SLOTS];
	logic             side_mem  [ORDER_SLOTS];
	logic [PW-1:0]    next_mem  [ORDER_SLOTS];
	logic [PW-1:0]    prev_mem  [ORDER_SLOTS];
	logic [AMT_W-1:0] amt_mem   [ORDER_SLOTS];
	logic [PW-1:0]    flink_mem [ORDER_SLOTS];
	logic [2*PW-1:0]  bid_mem   [PRICE_TICKS];
	logic [2*PW-1:0]  ask_mem   [PRICE_TICKS];

	// memory ports
	logic [IDW-1:0]   dir_ra, dir_wa;
	logic [PW-1:0]    dir_rd, dir_wd;
	logic             dir_we;
	logic [SW-1:0]    rec_ra, rec_wa;
	logic [IDW-1:0]   ref_rd;
	logic [PRW-1:0]   prc_rd;
	logic             side_rd;
	logic             rec_we;
	logic [PW-1:0]    next_rd, prev_rd, next_wd, prev_wd;
	logic [SW-1:0]    next_wa, prev_wa;
	logic             next_we, prev_we;
	logic [AMT_W-1:0] amt_rd, amt_wd;
	logic [SW-1:0]    amt_wa;
	logic             amt_we;
	logic [SW-1:0]    flink_ra, flink_wa;
	logic [PW-1:0]    flink_rd, flink_wd;
	logic             flink_we;
	logic [PRW-1:0]   lvl_ra, lvl_wa;
	logic [2*PW-1:0]  bid_rd, ask_rd, lvl_wd;
	logic             bid_we, ask_we;

	// control and datapath registers
	st_t              state_q, state_d;
	logic [CW-1:0]    clr_q;
	logic             op_q;
	logic [IDW-1:0]   ref_q;
	logic             sell_q;
	logic [PRW-1:0]   price_q;
	logic             bad_price_q;
	logic [AMT_W-1:0] qty_q;
	logic [PW-1:0]    slot_q;
	logic             c_sell_q;
	logic [PRW-1:0]   c_price_q;
	logic [PW-1:0]    c_next_q, c_prev_q;
	logic [PW-1:0]    h_q, lt_q;
	outcome_t         outcome_q;
	logic [PW-1:0]    free_head_q;
	logic [PRW:0]     ask_lo_q, bid_top_q;

	logic                   out_vld_q;
	logic                   o_status_q;
	logic [REF_OUT_W-1:0]   o_buyer_q, o_seller_q;
	logic [PRICE_OUT_W-1:0] o_price_q;
	logic [AMT_W-1:0]       o_amt_q;
	logic [OUTCOME_W-1:0]   o_outcome_q;
	logic                   o_last_q;

	// shared combinational terms
	logic             accept, out_free;
	logic [AMT_W-1:0] fill, qty_left;
	logic             full;
	logic [PRW-1:0]   opp_p;
	logic [2*PW-1:0]  opp_rd, own_rd, c_rd;
	logic [PW-1:0]    opp_head, opp_tail, own_head, own_tail;
	logic             ref_bad_in;
	logic [PRW:0]     bid_top_m1, price_ext;

	assign accept     = orders.valid && orders.ready;
	assign out_free   = !out_vld_q || results.ready;
	assign ref_bad_in = orders.order_ref >= 32'(ORDER_IDS);
	assign fill       = (qty_q < amt_rd) ? qty_q : amt_rd;
	assign full       = amt_rd <= qty_q;
	assign qty_left   = qty_q - fill;
	assign bid_top_m1 = bid_top_q - 1'b1;
	assign price_ext  = {1'b0, price_q};
	assign opp_p      = sell_q ? bid_top_m1[PRW-1:0] : ask_lo_q[PRW-1:0];
	assign opp_rd     = sell_q ? bid_rd : ask_rd;
	assign own_rd     = sell_q ? ask_rd : bid_rd;
	assign c_rd       = c_sell_q ? ask_rd : bid_rd;
	assign opp_head   = opp_rd[2*PW-1:PW];
	assign opp_tail   = opp_rd[PW-1:0];
	assign own_head   = own_rd[2*PW-1:PW];
	assign own_tail   = own_rd[PW-1:0];

	assign orders.ready = (state_q == ST_IDLE);

	// memory read ports
	always_ff @(posedge clk) begin
		dir_rd   <= dir_mem[dir_ra];
		ref_rd   <= ref_mem[rec_ra];
		prc_rd   <= prc_mem[rec_ra];
		side_rd  <= side_mem[rec_ra];
		next_rd  <= next_mem[rec_ra];
		prev_rd  <= prev_mem[rec_ra];
		amt_rd   <= amt_mem[rec_ra];
		flink_rd <= flink_mem[flink_ra];
		bid_rd   <= bid_mem[lvl_ra];
		ask_rd   <= ask_mem[lvl_ra];
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (rec_we) begin
			ref_mem[rec_wa]  <= ref_q;
			prc_mem[rec_wa]  <= price_q;
			side_mem[rec_wa] <= sell_q;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (amt_we) begin
			amt_mem[amt_wa] <= amt_wd;
		end
		if (flink_we) begin
			flink_mem[flink_wa] <= flink_wd;
		end
		if (bid_we) begin
			bid_mem[lvl_wa] <= lvl_wd;
		end
		if (ask_we) begin
			ask_mem[lvl_wa] <= lvl_wd;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read addresses and write controls
	always_comb begin
		state_d  = state_q;
		dir_ra   = ref_q;
		rec_ra   = h_q[SW-1:0];
		flink_ra = free_head_q[SW-1:0];
		lvl_ra   = price_q;
		dir_we   = 1'b0;
		dir_wa   = ref_q;
		dir_wd   = NO_SLOT;
		rec_we   = 1'b0;
		rec_wa   = slot_q[SW-1:0];
		next_we  = 1'b0;
		next_wa  = slot_q[SW-1:0];
		next_wd  = NO_SLOT;
		prev_we  = 1'b0;
		prev_wa  = slot_q[SW-1:0];
		prev_wd  = NO_SLOT;
		amt_we   = 1'b0;
		amt_wa   = h_q[SW-1:0];
		amt_wd   = amt_rd - fill;
		flink_we = 1'b0;
		flink_wa = slot_q[SW-1:0];
		flink_wd = free_head_q;
		bid_we   = 1'b0;
		ask_we   = 1'b0;
		lvl_wa   = price_q;
		lvl_wd   = {NO_SLOT, NO_SLOT};

		unique case (state_q)
			ST_CLEAR: begin
				dir_wa   = clr_q[IDW-1:0];
				dir_we   = {1'b0, clr_q} < (CW+1)'(ORDER_IDS);
				lvl_wa   = clr_q[PRW-1:0];
				bid_we   = {1'b0, clr_q} < (CW+1)'(PRICE_TICKS);
				ask_we   = bid_we;
				flink_wa = clr_q[SW-1:0];
				flink_we = {1'b0, clr_q} < (CW+1)'(ORDER_SLOTS);
				flink_wd = ({1'b0, clr_q} + 1'b1 < (CW+1)'(ORDER_SLOTS)) ?
					PW'({1'b0, clr_q} + 1'b1) : NO_SLOT;
				if (clr_q == CW'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				dir_ra = orders.order_ref[IDW-1:0];
				if (accept) begin
					state_d = ref_bad_in ? ST_STAT : ST_DIR;
				end
			end
			ST_DIR: begin
				rec_ra = dir_rd[SW-1:0];
				priority if (op_q == OP_CANCEL) begin
					state_d = (dir_rd == NO_SLOT) ? ST_STAT : ST_CREC;
				end else if (dir_rd != NO_SLOT || bad_price_q || free_head_q == NO_SLOT) begin
					state_d = ST_STAT;
				end else begin
					state_d = ST_ALLOC;
				end
			end
			ST_CREC: begin
				lvl_ra  = prc_rd;
				state_d = ST_CLVL;
			end
			ST_CLVL: begin
				// unlink the cancelled slot from its level queue
				lvl_wa  = c_price_q;
				lvl_wd  = {(c_prev_q == NO_SLOT) ? c_next_q : c_rd[2*PW-1:PW],
					(c_next_q == NO_SLOT) ? c_prev_q : c_rd[PW-1:0]};
				bid_we  = !c_sell_q;
				ask_we  = c_sell_q;
				next_we = c_prev_q != NO_SLOT;
				next_wa = c_prev_q[SW-1:0];
				next_wd = c_next_q;
				prev_we = c_next_q != NO_SLOT;
				prev_wa = c_next_q[SW-1:0];
				prev_wd = c_prev_q;
				dir_we   = 1'b1;
				flink_we = 1'b1;
				state_d  = ST_STAT;
			end
			ST_ALLOC: begin
				state_d = (qty_q == '0) ? ST_FIN : ST_SCAN;
			end
			ST_SCAN: begin
				lvl_ra = opp_p;
				if (sell_q) begin
					state_d = (bid_top_q <= price_ext) ? ST_FIN : ST_CHK;
				end else begin
					state_d = (ask_lo_q > price_ext) ? ST_FIN : ST_CHK;
				end
			end
			ST_CHK: begin
				lvl_ra  = opp_p;
				rec_ra  = opp_head[SW-1:0];
				state_d = (opp_head != NO_SLOT) ? ST_MATCH : ST_SCAN;
			end
			ST_MATCH: begin
				// trade against the head of the best level
				if (out_free) begin
					amt_we   = 1'b1;
					lvl_wa   = opp_p;
					lvl_wd   = (next_rd == NO_SLOT) ? {NO_SLOT, NO_SLOT} : {next_rd, lt_q};
					bid_we   = full && sell_q;
					ask_we   = full && !sell_q;
					prev_we  = full && (next_rd != NO_SLOT);
					prev_wa  = next_rd[SW-1:0];
					dir_we   = full;
					dir_wa   = ref_rd;
					flink_we = full;
					flink_wa = h_q[SW-1:0];
					state_d  = (qty_left == '0) ? ST_FIN : ST_SCAN;
				end
			end
			ST_FIN: begin
				if (qty_q != '0) begin
					// rest the remainder: write record, fetch own level
					rec_we  = 1'b1;
					amt_we  = 1'b1;
					amt_wa  = slot_q[SW-1:0];
					amt_wd  = qty_q;
					dir_we  = 1'b1;
					dir_wd  = slot_q;
					next_we = 1'b1;
					state_d = ST_APPEND;
				end else begin
					flink_we = 1'b1;
					state_d  = ST_STAT;
				end
			end
			ST_APPEND: begin
				// link the new slot at the tail of its level
				bid_we  = !sell_q;
				ask_we  = sell_q;
				prev_we = 1'b1;
				if (own_head == NO_SLOT) begin
					lvl_wd = {slot_q, slot_q};
				end else begin
					prev_wd = own_tail;
					next_we = 1'b1;
					next_wa = own_tail[SW-1:0];
					next_wd = slot_q;
					lvl_wd  = {own_head, slot_q};
				end
				state_d = ST_STAT;
			end
			ST_STAT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			free_head_q <= '0;
			ask_lo_q    <= (PRW+1)'(PRICE_TICKS);
			bid_top_q   <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_CLVL: begin
					free_head_q <= slot_q;
				end
				ST_ALLOC: begin
					free_head_q <= flink_rd;
				end
				ST_CHK: begin
					// level empty: tighten the best-price bound
					if (opp_head == NO_SLOT) begin
						if (sell_q) begin
							bid_top_q <= bid_top_m1;
						end else begin
							ask_lo_q <= ask_lo_q + 1'b1;
						end
					end
				end
				ST_MATCH: begin
					if (out_free && full) begin
						free_head_q <= h_q;
					end
				end
				ST_FIN: begin
					if (qty_q == '0) begin
						free_head_q <= slot_q;
					end
				end
				ST_APPEND: begin
					if (sell_q) begin
						if (price_ext < ask_lo_q) begin
							ask_lo_q <= price_ext;
						end
					end else if (price_ext + 1'b1 > bid_top_q) begin
						bid_top_q <= price_ext + 1'b1;
					end
				end
				default: begin
				end
			endcase

			// hold the result until transferred
			if ((state_q == ST_MATCH || state_q == ST_STAT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q        <= orders.op;
					ref_q       <= orders.order_ref[IDW-1:0];
					sell_q      <= orders.is_sell;
					price_q     <= orders.limit_price[PRW-1:0];
					bad_price_q <= orders.limit_price >= 32'(PRICE_TICKS);
					qty_q       <= orders.amount;
					outcome_q   <= OC_ID_RANGE;
				end
			end
			ST_DIR: begin
				priority if (op_q == OP_CANCEL) begin
					slot_q    <= dir_rd;
					outcome_q <= OC_NOT_FOUND;
				end else if (dir_rd != NO_SLOT) begin
					outcome_q <= OC_DUPLICATE;
				end else if (bad_price_q) begin
					outcome_q <= OC_PRICE_RANGE;
				end else begin
					slot_q    <= free_head_q;
					outcome_q <= OC_POOL_FULL;
				end
			end
			ST_CREC: begin
				c_sell_q  <= side_rd;
				c_price_q <= prc_rd;
				c_next_q  <= next_rd;
				c_prev_q  <= prev_rd;
			end
			ST_CLVL: begin
				outcome_q <= OC_CANCELLED;
			end
			ST_CHK: begin
				h_q  <= opp_head;
				lt_q <= opp_tail;
			end
			ST_MATCH: begin
				if (out_free) begin
					qty_q       <= qty_left;
					o_status_q  <= 1'b0;
					o_buyer_q   <= sell_q ? REF_OUT_W'(ref_rd) : REF_OUT_W'(ref_q);
					o_seller_q  <= sell_q ? REF_OUT_W'(ref_q) : REF_OUT_W'(ref_rd);
					o_price_q   <= PRICE_OUT_W'(opp_p);
					o_amt_q     <= fill;
					o_outcome_q <= OC_RESTED;
					o_last_q    <= 1'b0;
				end
			end
			ST_FIN: begin
				outcome_q <= (qty_q != '0) ? OC_RESTED : OC_FILLED;
			end
			ST_STAT: begin
				if (out_free) begin
					o_status_q  <= 1'b1;
					o_buyer_q   <= '0;
					o_seller_q  <= '0;
					o_price_q   <= '0;
					o_amt_q     <= '0;
					o_outcome_q <= outcome_q;
					o_last_q    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid        = out_vld_q;
	assign results.is_status    = o_status_q;
	assign results.buyer_ref    = o_buyer_q;
	assign results.seller_ref   = o_seller_q;
	assign results.trade_price  = o_price_q;
	assign results.trade_amount = o_amt_q;
	assign results.outcome      = o_outcome_q;
	assign results.last         = o_last_q;

endmodule
